// ----- sv/assert_macros.svh -----
// assertion macros used by the ring queue unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- sv/rqed_pkg.sv -----
// shared constants and codes of the ring queue unit
`timescale 1ns / 1ps
`default_nettype none
package rqed_pkg;

  localparam int MAX_DEPTH      = 32;
  localparam int MAX_ELEM_BYTES = 8;

  // request action codes
  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_POP   = 3'd1;
  localparam logic [2:0] ACT_PEEK  = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_DEL   = 3'd4;
  localparam logic [2:0] ACT_DEC   = 3'd5;
  localparam logic [2:0] ACT_CLEAR = 3'd6;

  // configuration register indexes
  localparam logic [0:0] REG_QUEUE_LENGTH  = 1'b0;
  localparam logic [0:0] REG_ELEMENT_BYTES = 1'b1;

  // configuration reset values
  localparam logic [5:0] QUEUE_LENGTH_RST  = 6'd32;
  localparam logic [3:0] ELEMENT_BYTES_RST = 4'd8;

endpackage
`default_nettype wire

// ----- sv/ring_queue_with_end_delete_unit.sv -----
// ring queue with end delete: slot memory, pointers and request sequencer
// an accepted request goes to S_RD for the slot memory read; out_valid rises once S_RD loads the free result register
// a new request is taken only in S_IDLE, once the last one has loaded its result after the slot read and write-back
// a waiting result does not block the next request; only a second result stalls
// reset: head and tail go to zero, per-slot valid bits clear so every slot reads zero
// reset: queue_length goes to 32 and element_bytes to 8; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ring_queue_with_end_delete_unit #(
  parameter int MAX_DEPTH      = rqed_pkg::MAX_DEPTH,
  parameter int MAX_ELEM_BYTES = rqed_pkg::MAX_ELEM_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [63:0] push_data,
  input  logic [5:0]  item_index,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [63:0] read_data,
  output logic [4:0]  entry_count,
  output logic        is_empty
);

  // pointer, length and data widths
  localparam int PW = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (LW + 1 > 7) ? LW + 1 : 7;
  localparam int DW = 8 * MAX_ELEM_BYTES;

  typedef enum logic {S_IDLE, S_RD} state_t;

  state_t          state;
  logic [5:0]      queue_length;
  logic [3:0]      element_bytes;
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;

  // request held during the read-modify-write
  logic [2:0]      act_q;
  logic [DW-1:0]   pdata_q;
  logic [PW-1:0]   idx_q;
  logic            idx_ok_q;

  // slot memory with per-slot valid bits
  logic [DW-1:0]        mem [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] vld;
  logic [DW-1:0]        rdata;
  logic                 rd_vld;

  logic            accept;
  logic            load;
  logic [AW-1:0]   len;
  logic [3:0]      eb_eff;
  logic [DW-1:0]   mask;
  logic [AW-1:0]   idx_f;
  logic            idx_ok;
  logic [PW-1:0]   rd_addr;

  logic            st_next;
  logic [DW-1:0]   dat_next;
  logic [PW-1:0]   head_next;
  logic [PW-1:0]   tail_next;
  logic            wr_en;
  logic [PW-1:0]   wr_addr;
  logic [DW-1:0]   wr_data;
  logic [4:0]      count_next;
  logic            mem_we;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p, input logic [AW-1:0] l);
    logic [AW-1:0] n;
    n = p + AW'(1);
    return (n >= l) ? '0 : n;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  // result register free or being emptied this cycle
  assign load     = (state == S_RD) && (!out_valid || out_ready);
  assign mem_we   = load && wr_en;

  // effective length and byte mask from the clamped registers
  always_comb begin
    len = AW'(queue_length);
    if (len < AW'(2)) len = AW'(2);
    if (len > AW'(MAX_DEPTH)) len = AW'(MAX_DEPTH);
    eb_eff = element_bytes;
    if (eb_eff == 4'd0) eb_eff = 4'd1;
    if (eb_eff > 4'(MAX_ELEM_BYTES)) eb_eff = 4'(MAX_ELEM_BYTES);
    for (int k = 0; k < MAX_ELEM_BYTES; k++) begin
      mask[8*k +: 8] = (4'(k) < eb_eff) ? 8'hFF : 8'h00;
    end
  end

  // index fold and read address, evaluated in the accept cycle
  always_comb begin
    logic [AW-1:0] raw;
    raw    = AW'(item_index);
    idx_f  = (raw < len) ? raw : raw - len;
    idx_ok = (idx_f < len);
    if (action == rqed_pkg::ACT_POP || action == rqed_pkg::ACT_PEEK || !idx_ok) begin
      rd_addr = head;
    end else begin
      rd_addr = idx_f[PW-1:0];
    end
  end

  // modify step on the slot read back from memory
  always_comb begin
    logic [DW-1:0] v;
    logic [DW-1:0] vm;
    logic [AW-1:0] head_a;
    logic [AW-1:0] tail_a;
    logic [AW-1:0] head_adv;
    logic [AW-1:0] tail_adv;
    logic [AW-1:0] idx_adv;
    logic [AW-1:0] tail_dec;
    logic [AW-1:0] hn_a;
    logic [AW-1:0] tn_a;
    logic [AW-1:0] cnt_a;
    logic          empty;
    logic          rm_head;
    logic          rm_tail;
    v        = rd_vld ? rdata : '0;
    vm       = v & mask;
    head_a   = AW'(head);
    tail_a   = AW'(tail);
    head_adv = advance(head_a, len);
    tail_adv = advance(tail_a, len);
    idx_adv  = advance(AW'(idx_q), len);
    tail_dec = (tail_a != '0) ? tail_a - AW'(1) : len - AW'(1);
    empty    = (head == tail);
    // entry is removable only at the head or as the last entry
    rm_head  = (head_a == AW'(idx_q));
    rm_tail  = (tail_a == idx_adv);

    st_next   = 1'b1;
    dat_next  = '0;
    head_next = head;
    tail_next = tail;
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_data   = '0;

    case (act_q)
      rqed_pkg::ACT_PUSH: begin
        if (tail_adv != head_a) begin
          wr_en     = 1'b1;
          wr_addr   = tail;
          wr_data   = pdata_q & mask;
          tail_next = tail_adv[PW-1:0];
          st_next   = 1'b0;
        end
      end
      rqed_pkg::ACT_POP: begin
        if (!empty) begin
          dat_next  = vm;
          wr_en     = 1'b1;
          wr_addr   = head;
          head_next = head_adv[PW-1:0];
          st_next   = 1'b0;
        end
      end
      rqed_pkg::ACT_PEEK: begin
        if (!empty) begin
          dat_next = vm;
          st_next  = 1'b0;
        end
      end
      rqed_pkg::ACT_READ: begin
        if (!empty && idx_ok_q) begin
          dat_next = vm;
          st_next  = 1'b0;
        end
      end
      rqed_pkg::ACT_DEL: begin
        if (!empty && idx_ok_q) begin
          dat_next = vm;
          wr_en    = 1'b1;
          if (rm_head) begin
            head_next = head_adv[PW-1:0];
            st_next   = 1'b0;
          end else if (rm_tail) begin
            tail_next = tail_dec[PW-1:0];
            st_next   = 1'b0;
          end
        end
      end
      rqed_pkg::ACT_DEC: begin
        if (!empty && idx_ok_q) begin
          dat_next = vm;
          if (v[7:0] != 8'd0) begin
            wr_en        = 1'b1;
            wr_data      = v;
            wr_data[7:0] = v[7:0] - 8'd1;
            // byte 0 reaches zero: entry goes if it sits at an end
            if (v[7:0] == 8'd1) begin
              if (rm_head) begin
                head_next = head_adv[PW-1:0];
                st_next   = 1'b0;
              end else if (rm_tail) begin
                tail_next = tail_dec[PW-1:0];
                st_next   = 1'b0;
              end
            end
          end
        end
      end
      rqed_pkg::ACT_CLEAR: begin
        head_next = '0;
        tail_next = '0;
        st_next   = 1'b0;
      end
      default: begin
      end
    endcase

    // occupancy after the step, wrapped by the ring length
    hn_a  = AW'(head_next);
    tn_a  = AW'(tail_next);
    cnt_a = (tn_a >= hn_a) ? tn_a - hn_a : len + tn_a - hn_a;
    count_next = cnt_a[4:0];
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rdata <= mem[rd_addr];
    end
  end

  // valid bits: a slot never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[wr_addr] <= 1'b1;
      end
      if (accept) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // sequencer, pointers, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      tail          <= '0;
      queue_length  <= rqed_pkg::QUEUE_LENGTH_RST;
      element_bytes <= rqed_pkg::ELEMENT_BYTES_RST;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rqed_pkg::REG_QUEUE_LENGTH:  queue_length  <= cfg_data;
          rqed_pkg::REG_ELEMENT_BYTES: element_bytes <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
      // result taken and no new one loaded behind it
      if (out_valid && out_ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          if (load) begin
            head      <= head_next;
            tail      <= tail_next;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    // payload registers
    if (accept) begin
      act_q    <= action;
      pdata_q  <= push_data[DW-1:0];
      idx_q    <= idx_f[PW-1:0];
      idx_ok_q <= idx_ok;
    end
    if (load) begin
      status      <= st_next;
      read_data   <= 64'(dat_next);
      entry_count <= count_next;
      is_empty    <= (head_next == tail_next);
    end
  end

  // an accepted request always goes to its memory read-back step
  `ASSERT_NEXT(a_accept_rd, clk, rst, accept, state == S_RD)
  // a result taken into the register is shown and frees the request side
  `ASSERT_NEXT(a_load_out, clk, rst, load, out_valid && state == S_IDLE)
  // an empty queue always reports zero entries
  `ASSERT_IMPLY(a_empty_count, clk, rst, out_valid && is_empty, entry_count == 5'd0)

endmodule
`default_nettype wire
